// ===== hdl/link_provisioning_fsm_unit_assert.svh =====
// Assertion macros for the link provisioning controller.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef LINK_PROVISIONING_FSM_UNIT_ASSERT_SVH
`define LINK_PROVISIONING_FSM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset
`define LPF_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("link provisioning check failed");

// Antecedent in one cycle implies consequent in the next
`define LPF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("link provisioning sequence check failed");

`else

`define LPF_ASSERT(name, cond)
`define LPF_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hdl/lpf_pkg.sv =====
package lpf_pkg;

  // Field widths
  localparam int DELAY_BITS     = 20;
  localparam int CFG_DELAY_BITS = 20;
  localparam int LIMIT_BITS     = 8;
  localparam int ACTION_BITS    = 11;
  localparam int CMD_BITS       = 3;
  localparam int REASON_BITS    = 2;
  localparam int STATE_BITS     = 3;
  localparam int ADDR_BITS      = 4;
  localparam int DATA_BITS      = 32;

  // Width for the doubling compare, one bit above the wider operand
  localparam int BACKOFF_CALC_BITS =
    ((DELAY_BITS > CFG_DELAY_BITS) ? DELAY_BITS : CFG_DELAY_BITS) + 1;

  // Register reset values
  localparam logic [CFG_DELAY_BITS-1:0] BACKOFF_INITIAL_RST = CFG_DELAY_BITS'(1000);
  localparam logic [CFG_DELAY_BITS-1:0] BACKOFF_MAX_RST     = CFG_DELAY_BITS'(60000);
  localparam logic [LIMIT_BITS-1:0]     AUTH_FAIL_LIMIT_RST = LIMIT_BITS'(3);
  localparam logic [LIMIT_BITS-1:0]     AUTH_COUNT_MAX      = '1;

  // Register indexes (byte address divided by four)
  localparam logic [1:0] REG_BACKOFF_INITIAL = 2'd0;
  localparam logic [1:0] REG_BACKOFF_MAX     = 2'd1;
  localparam logic [1:0] REG_AUTH_FAIL_LIMIT = 2'd2;

  // Events
  localparam logic [CMD_BITS-1:0] EV_BOOT   = 3'd0;
  localparam logic [CMD_BITS-1:0] EV_CREDS  = 3'd1;
  localparam logic [CMD_BITS-1:0] EV_UP     = 3'd2;
  localparam logic [CMD_BITS-1:0] EV_FAILED = 3'd3;
  localparam logic [CMD_BITS-1:0] EV_RETRY  = 3'd4;
  localparam logic [CMD_BITS-1:0] EV_RESET  = 3'd5;

  // Failure reasons
  localparam logic [REASON_BITS-1:0] REASON_TRANSIENT = 2'd0;
  localparam logic [REASON_BITS-1:0] REASON_AUTH      = 2'd1;
  localparam logic [REASON_BITS-1:0] REASON_NO_AP     = 2'd2;

  // Action bit positions
  localparam int A_ARM      = 0;
  localparam int A_DOWN     = 1;
  localparam int A_ERASE    = 2;
  localparam int A_REBOOT   = 3;
  localparam int A_DISCARD  = 4;
  localparam int A_CONNECT  = 5;
  localparam int A_START    = 6;
  localparam int A_UNPROVEN = 7;
  localparam int A_COMMIT   = 8;
  localparam int A_STOP     = 9;
  localparam int A_UP       = 10;

  typedef enum logic [STATE_BITS-1:0] {
    ST_BOOT       = 3'd0,
    ST_PROV       = 3'd1,
    ST_CONNECTING = 3'd2,
    ST_CONNECTED  = 3'd3,
    ST_RETRY      = 3'd4
  } state_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]    command;
    logic                   creds_stored;
    logic                   creds_proven;
    logic [REASON_BITS-1:0] fail_reason;
  } in_item_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0] actions;
    logic [DELAY_BITS-1:0]  retry_delay;
    logic                   failure_flag;
    logic [REASON_BITS-1:0] failure_code;
    logic [STATE_BITS-1:0]  new_state;
    logic                   creds_valid;
  } out_item_t;

endpackage

// ===== hdl/link_provisioning_fsm_unit.sv =====
// Link provisioning controller. Each accepted request is one event and
// yields exactly one result, registered in the output register. A new
// request is taken every cycle while the output register is empty or being
// drained in the same cycle, so the block sustains one event per cycle; that
// figure is set by the combinational next-state logic around the state
// registers (state, credentials, session, auth failure count, backoff).
// Configuration writes take effect at once; a new backoff_initial reaches the
// running backoff only when that backoff is next reloaded.
`include "link_provisioning_fsm_unit_assert.svh"

module link_provisioning_fsm_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lpf_pkg::in_item_t                    in_data,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lpf_pkg::out_item_t                   out_data,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lpf_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [lpf_pkg::DATA_BITS-1:0]        pwdata,
  output logic [lpf_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);

  localparam int DB = lpf_pkg::DELAY_BITS;
  localparam int CB = lpf_pkg::CFG_DELAY_BITS;
  localparam int KB = lpf_pkg::BACKOFF_CALC_BITS;
  localparam int LB = lpf_pkg::LIMIT_BITS;

  // Configuration registers
  logic [CB-1:0] backoff_initial_r;
  logic [CB-1:0] backoff_max_r;
  logic [LB-1:0] auth_fail_limit_r;

  // Controller state
  lpf_pkg::state_t state_r, state_nxt;
  logic            creds_r, creds_nxt;
  logic            session_r, session_nxt;
  logic [LB-1:0]   auth_cnt_r, auth_cnt_nxt;
  logic [DB-1:0]   backoff_r, backoff_nxt;

  // Output register
  logic               out_valid_r;
  lpf_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_accept;
  logic cfg_write;
  logic [1:0] cfg_index;

  // Event decode
  logic [lpf_pkg::REASON_BITS-1:0] reason;
  logic both_creds;
  logic boot_ev, prov_ev, up_ev, retry_ev, reset_ev;
  logic sess_fail, cred_fail, auth_trip, wipe, arm;
  logic [LB-1:0] auth_cnt_inc;
  logic [DB-1:0] backoff_init_d;
  logic [DB-1:0] backoff_dbl;
  logic [KB-1:0] cur_ext, max_ext, dbl_ext;
  logic [lpf_pkg::ACTION_BITS-1:0] actions;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (cfg_index)
      lpf_pkg::REG_BACKOFF_INITIAL: prdata = lpf_pkg::DATA_BITS'(backoff_initial_r);
      lpf_pkg::REG_BACKOFF_MAX:     prdata = lpf_pkg::DATA_BITS'(backoff_max_r);
      lpf_pkg::REG_AUTH_FAIL_LIMIT: prdata = lpf_pkg::DATA_BITS'(auth_fail_limit_r);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_initial_r <= lpf_pkg::BACKOFF_INITIAL_RST;
      backoff_max_r     <= lpf_pkg::BACKOFF_MAX_RST;
      auth_fail_limit_r <= lpf_pkg::AUTH_FAIL_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        lpf_pkg::REG_BACKOFF_INITIAL: backoff_initial_r <= pwdata[CB-1:0];
        lpf_pkg::REG_BACKOFF_MAX:     backoff_max_r     <= pwdata[CB-1:0];
        lpf_pkg::REG_AUTH_FAIL_LIMIT: auth_fail_limit_r <= pwdata[LB-1:0];
        default: ;
      endcase
    end
  end

  // Fold the unused reason code onto transient
  assign reason = (in_data.fail_reason > lpf_pkg::REASON_NO_AP) ?
                  lpf_pkg::REASON_TRANSIENT : in_data.fail_reason;
  assign both_creds = in_data.creds_stored && in_data.creds_proven;

  // Classify the event against the current state
  assign reset_ev = (in_data.command == lpf_pkg::EV_RESET);
  assign boot_ev  = (state_r == lpf_pkg::ST_BOOT) && (in_data.command == lpf_pkg::EV_BOOT);
  assign prov_ev  = (state_r == lpf_pkg::ST_PROV) && (in_data.command == lpf_pkg::EV_CREDS);
  assign up_ev    = (state_r == lpf_pkg::ST_CONNECTING) && (in_data.command == lpf_pkg::EV_UP);
  assign retry_ev = (state_r == lpf_pkg::ST_RETRY) && (in_data.command == lpf_pkg::EV_RETRY);
  assign sess_fail = (state_r == lpf_pkg::ST_CONNECTING) &&
                     (in_data.command == lpf_pkg::EV_FAILED) && session_r;
  assign cred_fail = (in_data.command == lpf_pkg::EV_FAILED) &&
                     ((state_r == lpf_pkg::ST_CONNECTED) ||
                      ((state_r == lpf_pkg::ST_CONNECTING) && !session_r));

  // Saturating auth failure count and limit check
  assign auth_cnt_inc = (auth_cnt_r != lpf_pkg::AUTH_COUNT_MAX) ?
                        auth_cnt_r + LB'(1) : auth_cnt_r;
  assign auth_trip = cred_fail && (reason == lpf_pkg::REASON_AUTH) &&
                     (auth_cnt_inc >= auth_fail_limit_r);
  assign wipe = reset_ev || auth_trip;
  assign arm  = cred_fail && !auth_trip;

  // Backoff reload value and saturating doubling
  assign backoff_init_d = DB'(KB'(backoff_initial_r));
  assign cur_ext = KB'(backoff_r);
  assign max_ext = KB'(backoff_max_r);
  assign dbl_ext = cur_ext << 1;
  assign backoff_dbl = ((cur_ext >= max_ext) || (dbl_ext > max_ext)) ?
                       DB'(max_ext) : DB'(dbl_ext);

  // Next state
  always_comb begin
    state_nxt    = state_r;
    creds_nxt    = creds_r;
    session_nxt  = session_r;
    auth_cnt_nxt = auth_cnt_r;
    backoff_nxt  = backoff_r;
    if (wipe) begin
      state_nxt    = lpf_pkg::ST_PROV;
      creds_nxt    = 1'b0;
      session_nxt  = 1'b0;
      auth_cnt_nxt = '0;
      backoff_nxt  = backoff_init_d;
    end else if (boot_ev) begin
      state_nxt = both_creds ? lpf_pkg::ST_CONNECTING : lpf_pkg::ST_PROV;
      creds_nxt = both_creds;
    end else if (prov_ev) begin
      state_nxt   = lpf_pkg::ST_CONNECTING;
      session_nxt = 1'b1;
    end else if (up_ev) begin
      state_nxt    = lpf_pkg::ST_CONNECTED;
      creds_nxt    = creds_r || session_r;
      session_nxt  = 1'b0;
      auth_cnt_nxt = '0;
      backoff_nxt  = backoff_init_d;
    end else if (sess_fail) begin
      state_nxt   = lpf_pkg::ST_PROV;
      session_nxt = 1'b0;
      backoff_nxt = backoff_init_d;
    end else if (arm) begin
      state_nxt   = lpf_pkg::ST_RETRY;
      backoff_nxt = backoff_dbl;
      if (reason == lpf_pkg::REASON_AUTH) begin
        auth_cnt_nxt = auth_cnt_inc;
      end
    end else if (retry_ev) begin
      state_nxt = lpf_pkg::ST_CONNECTING;
    end
  end

  // Outputs
  always_comb begin
    actions = '0;
    actions[lpf_pkg::A_ARM]      = arm;
    actions[lpf_pkg::A_DOWN]     = (state_r == lpf_pkg::ST_CONNECTED) &&
                                   ((in_data.command == lpf_pkg::EV_FAILED) || reset_ev);
    actions[lpf_pkg::A_ERASE]    = wipe || (boot_ev && !both_creds &&
                                   (in_data.creds_stored || in_data.creds_proven));
    actions[lpf_pkg::A_REBOOT]   = wipe;
    actions[lpf_pkg::A_DISCARD]  = sess_fail;
    actions[lpf_pkg::A_CONNECT]  = (boot_ev && both_creds) || retry_ev;
    actions[lpf_pkg::A_START]    = boot_ev && !both_creds;
    actions[lpf_pkg::A_UNPROVEN] = prov_ev;
    actions[lpf_pkg::A_COMMIT]   = up_ev && session_r;
    actions[lpf_pkg::A_STOP]     = up_ev && session_r;
    actions[lpf_pkg::A_UP]       = up_ev;

    out_data_nxt.actions      = actions;
    out_data_nxt.retry_delay  = arm ? backoff_r : '0;
    out_data_nxt.failure_flag = sess_fail || cred_fail;
    out_data_nxt.failure_code = (sess_fail || cred_fail) ? reason : lpf_pkg::REASON_TRANSIENT;
    out_data_nxt.new_state    = state_nxt;
    out_data_nxt.creds_valid  = creds_nxt;
  end

  // Advance state on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lpf_pkg::ST_BOOT;
      creds_r    <= 1'b0;
      session_r  <= 1'b0;
      auth_cnt_r <= '0;
      backoff_r  <= DB'(KB'(lpf_pkg::BACKOFF_INITIAL_RST));
    end else if (in_accept) begin
      state_r    <= state_nxt;
      creds_r    <= creds_nxt;
      session_r  <= session_nxt;
      auth_cnt_r <= auth_cnt_nxt;
      backoff_r  <= backoff_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  `LPF_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_r)
  `LPF_ASSERT(a_delay_only_when_armed,
    !out_valid_r || out_data_r.actions[lpf_pkg::A_ARM] || (out_data_r.retry_delay == '0))
  `LPF_ASSERT(a_code_needs_flag,
    !out_valid_r || out_data_r.failure_flag ||
    (out_data_r.failure_code == lpf_pkg::REASON_TRANSIENT))
  `LPF_ASSERT(a_prov_has_no_creds, (state_r != lpf_pkg::ST_PROV) || !creds_r)
  `LPF_ASSERT(a_retry_outside_session, (state_r != lpf_pkg::ST_RETRY) || !session_r)

endmodule
